/* rtl/core/md5_hash_engine_top_defines.svh */
// Assertion macros for the MD5 hash engine.
// Included by the top level; no other dependencies.
`ifndef MD5_HASH_ENGINE_TOP_DEFINES_SVH
`define MD5_HASH_ENGINE_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// check on every clock edge outside reset
`define MD5HE_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("%m: assertion failed");
// check on every clock edge, reset included
`define MD5HE_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("%m: assertion failed");
`else
`define MD5HE_ASSERT(lbl, prop)
`define MD5HE_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

/* rtl/core/md5he_pkg.sv */
// Shared types, constants and round tables for the MD5 hash engine.
// No dependencies.
package md5he_pkg;

	localparam logic [31:0] INIT_A = 32'h67452301;
	localparam logic [31:0] INIT_B = 32'hefcdab89;
	localparam logic [31:0] INIT_C = 32'h98badcfe;
	localparam logic [31:0] INIT_D = 32'h10325476;
	localparam logic [7:0]  PAD_BYTE = 8'h80;
	// first byte offset that no longer leaves room for the length words
	localparam logic [5:0]  LEN_ROOM = 6'd56;
	localparam logic [5:0]  LAST_POS = 6'd63;
	localparam logic [5:0]  LAST_ROUND = 6'd63;

	// commands from the controller to the datapath
	typedef struct packed {
		logic       take_byte;  // store data_byte, bump the byte count
		logic       pad;        // 0x80, zero fill, length if it fits
		logic       len_fill;   // zero block plus length words
		logic       round_en;   // run one compression round
		logic [5:0] round_idx;
		logic       add;        // fold working words into the chaining words
		logic       finish;     // load the digest, restart the message
	} md5he_cmd_t;

	function automatic logic [31:0] md5he_sine(input logic [5:0] r);
		logic [31:0] k;
		case (r)
			6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
			6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
			6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
			6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
			6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
			6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
			6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
			6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
			6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
			6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
			6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
			6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
			6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
			6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
			6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
			6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
			6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
			6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
			6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
			6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
			6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
			6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
			6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
			6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
			6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
			6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
			6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
			6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
			6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
			6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
			6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
			6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
			default: k = 32'h0;
		endcase
		return k;
	endfunction

	// rotate amount: by round group and round mod 4
	function automatic logic [4:0] md5he_shift(input logic [5:0] r);
		logic [4:0] s;
		case ({r[5:4], r[1:0]})
			4'd0:  s = 5'd7;   4'd1:  s = 5'd12;
			4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
			4'd4:  s = 5'd5;   4'd5:  s = 5'd9;
			4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
			4'd8:  s = 5'd4;   4'd9:  s = 5'd11;
			4'd10: s = 5'd16;  4'd11: s = 5'd23;
			4'd12: s = 5'd6;   4'd13: s = 5'd10;
			4'd14: s = 5'd15;  4'd15: s = 5'd21;
			default: s = 5'd0;
		endcase
		return s;
	endfunction

	// message word used in round r; only r mod 16 matters for the products
	function automatic logic [3:0] md5he_msg_idx(input logic [5:0] r);
		logic [3:0] lo;
		logic [3:0] k;
		lo = r[3:0];
		case (r[5:4])
			2'd0: k = lo;
			2'd1: k = 4'(lo * 4'd5 + 4'd1);
			2'd2: k = 4'(lo * 4'd3 + 4'd5);
			2'd3: k = 4'(lo * 4'd7);
			default: k = lo;
		endcase
		return k;
	endfunction

endpackage

/* rtl/core/md5he_ctrl.sv */
// Controller for the MD5 hash engine: item handshake, round sequencing, padding.
// Depends on md5he_pkg.
module md5he_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   byte_valid,
	input  logic                   last,
	output logic                   out_valid,
	input  logic                   out_ready,
	input  logic [5:0]             pos,
	output md5he_pkg::md5he_cmd_t  cmd
);
	import md5he_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_ROUND = 3'd1;
	localparam logic [2:0] S_ADD   = 3'd2;
	localparam logic [2:0] S_PAD   = 3'd3;
	localparam logic [2:0] S_LEN   = 3'd4;
	localparam logic [2:0] S_OUT   = 3'd5;

	localparam logic [1:0] PH_DATA  = 2'd0;  // full message block
	localparam logic [1:0] PH_PAD1  = 2'd1;  // padding block, length follows
	localparam logic [1:0] PH_FINAL = 2'd2;  // block carrying the length

	logic [2:0] state_q, state_d;
	logic [1:0] phase_q;
	logic [5:0] round_q;
	logic       last_q;
	logic       out_valid_q;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_ready = (state_q == S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.take_byte = byte_valid;
					if (byte_valid && pos == LAST_POS)
						state_d = S_ROUND;
					else if (last)
						state_d = S_PAD;
				end
			end
			S_ROUND: begin
				cmd.round_en  = 1'b1;
				cmd.round_idx = round_q;
				if (round_q == LAST_ROUND)
					state_d = S_ADD;
			end
			S_ADD: begin
				cmd.add = 1'b1;
				case (phase_q)
					PH_DATA:  state_d = last_q ? S_PAD : S_IDLE;
					PH_PAD1:  state_d = S_LEN;
					default:  state_d = S_OUT;
				endcase
			end
			S_PAD: begin
				cmd.pad = 1'b1;
				state_d = S_ROUND;
			end
			S_LEN: begin
				cmd.len_fill = 1'b1;
				state_d      = S_ROUND;
			end
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= PH_DATA;
			round_q     <= '0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			round_q <= (state_q == S_ROUND) ? round_q + 6'd1 : 6'd0;
			if (in_valid && in_ready) begin
				last_q  <= last;
				phase_q <= PH_DATA;
			end else if (cmd.pad) begin
				phase_q <= (pos >= LEN_ROOM) ? PH_PAD1 : PH_FINAL;
			end else if (cmd.len_fill) begin
				phase_q <= PH_FINAL;
			end
			if (cmd.finish)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

/* rtl/core/md5he_datapath.sv */
// Datapath for the MD5 hash engine: block words, byte count, round unit, digest.
// Depends on md5he_pkg.
module md5he_datapath (
	input  logic                   clk,
	input  logic                   arst_n,
	input  md5he_pkg::md5he_cmd_t  cmd,
	input  logic [7:0]             data_byte,
	output logic [5:0]             pos,
	output logic [31:0]            word_a,
	output logic [31:0]            word_b,
	output logic [31:0]            word_c,
	output logic [31:0]            word_d
);
	import md5he_pkg::*;

	logic [31:0] blk_q [16];
	logic [31:0] blk_d [16];
	logic [60:0] count_q;
	logic [63:0] bit_len;
	logic [31:0] ch_a_q, ch_b_q, ch_c_q, ch_d_q;  // chaining words
	logic [31:0] a_q, b_q, c_q, d_q;              // working words
	logic [31:0] out_a_q, out_b_q, out_c_q, out_d_q;

	logic [31:0] f_val, t_sum, rot_val, b_new;
	logic [63:0] rot_dbl;
	logic [5:0]  r;

	assign pos     = count_q[5:0];
	assign bit_len = {count_q, 3'b000};

	// block word updates
	always_comb begin
		int         w, j;
		logic [5:0] idx;
		for (w = 0; w < 16; w++)
			blk_d[w] = blk_q[w];
		idx = '0;
		if (cmd.take_byte)
			blk_d[pos[5:2]][{pos[1:0], 3'b000} +: 8] = data_byte;
		if (cmd.pad) begin
			for (w = 0; w < 16; w++) begin
				for (j = 0; j < 4; j++) begin
					idx = 6'(w * 4 + j);
					if (idx == pos)
						blk_d[w][j*8 +: 8] = PAD_BYTE;
					else if (idx > pos)
						blk_d[w][j*8 +: 8] = 8'h00;
				end
			end
			if (pos < LEN_ROOM) begin
				blk_d[14] = bit_len[31:0];
				blk_d[15] = bit_len[63:32];
			end
		end
		if (cmd.len_fill) begin
			for (w = 0; w < 14; w++)
				blk_d[w] = '0;
			blk_d[14] = bit_len[31:0];
			blk_d[15] = bit_len[63:32];
		end
	end

	always_ff @(posedge clk) begin
		for (int w = 0; w < 16; w++)
			blk_q[w] <= blk_d[w];
	end

	// one round
	assign r = cmd.round_idx;
	always_comb begin
		case (r[5:4])
			2'd0:    f_val = (b_q & c_q) | (~b_q & d_q);
			2'd1:    f_val = (b_q & d_q) | (c_q & ~d_q);
			2'd2:    f_val = b_q ^ c_q ^ d_q;
			default: f_val = c_q ^ (b_q | ~d_q);
		endcase
	end
	assign t_sum   = a_q + f_val + blk_q[md5he_msg_idx(r)] + md5he_sine(r);
	assign rot_dbl = {t_sum, t_sum} << md5he_shift(r);
	assign rot_val = rot_dbl[63:32];
	assign b_new   = b_q + rot_val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ch_a_q  <= INIT_A;
			ch_b_q  <= INIT_B;
			ch_c_q  <= INIT_C;
			ch_d_q  <= INIT_D;
			a_q     <= INIT_A;
			b_q     <= INIT_B;
			c_q     <= INIT_C;
			d_q     <= INIT_D;
		end else begin
			if (cmd.take_byte)
				count_q <= count_q + 61'd1;
			if (cmd.round_en) begin
				a_q <= d_q;
				d_q <= c_q;
				c_q <= b_q;
				b_q <= b_new;
			end else if (cmd.add) begin
				// working words mirror the chaining words between blocks
				ch_a_q <= ch_a_q + a_q;
				ch_b_q <= ch_b_q + b_q;
				ch_c_q <= ch_c_q + c_q;
				ch_d_q <= ch_d_q + d_q;
				a_q    <= ch_a_q + a_q;
				b_q    <= ch_b_q + b_q;
				c_q    <= ch_c_q + c_q;
				d_q    <= ch_d_q + d_q;
			end else if (cmd.finish) begin
				count_q <= '0;
				ch_a_q  <= INIT_A;
				ch_b_q  <= INIT_B;
				ch_c_q  <= INIT_C;
				ch_d_q  <= INIT_D;
				a_q     <= INIT_A;
				b_q     <= INIT_B;
				c_q     <= INIT_C;
				d_q     <= INIT_D;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_a_q <= ch_a_q;
			out_b_q <= ch_b_q;
			out_c_q <= ch_c_q;
			out_d_q <= ch_d_q;
		end
	end

	assign word_a = out_a_q;
	assign word_b = out_b_q;
	assign word_c = out_c_q;
	assign word_d = out_d_q;

endmodule

/* rtl/core/md5_hash_engine_top.sv */
// MD5 hash engine, top level: controller plus datapath.
// Depends on md5he_pkg, md5he_ctrl, md5he_datapath, md5_hash_engine_top_defines.svh.
//
// Input channel (in_valid/in_ready): one beat per message byte; data_byte counts
// when byte_valid is 1, last ends the message. A beat with last and no byte ends
// the message as it stands (an empty message is a single such beat).
// Output channel (out_valid/out_ready): one beat per message; word_a..word_d are
// the final chaining words, whose bytes, least significant first, form the digest.
// Bytes: one that does not close a 64-byte block leaves the engine ready for the
// next byte. One that closes a block is followed by the rounds on the single round
// unit and a fold into the chaining words, with in_ready low until both are done.
// Output: after a last beat whose block has room for the length, out_valid rises
// after a pad, the rounds, a fold and an output load; when another block is compressed
// first, a length-fill step, its rounds and a fold come before the output load.
// in_ready stays low until the output load; the next message is taken in while
// the digest waits. If a second digest is ready before the first is taken, the
// engine holds in its output state until out_ready frees the register.
// Reset: chaining words to the initial values, byte count to zero, no beat pending.
`include "md5_hash_engine_top_defines.svh"
module md5_hash_engine_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        byte_valid,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] word_a,
	output logic [31:0] word_b,
	output logic [31:0] word_c,
	output logic [31:0] word_d
);
	import md5he_pkg::*;

	md5he_cmd_t cmd;
	logic [5:0] pos;

	md5he_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.byte_valid (byte_valid),
		.last       (last),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.pos        (pos),
		.cmd        (cmd)
	);

	md5he_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.data_byte (data_byte),
		.pos       (pos),
		.word_a    (word_a),
		.word_b    (word_b),
		.word_c    (word_c),
		.word_d    (word_d)
	);

	// a byte that fills the block starts the compression at once
	`MD5HE_ASSERT(a_block_full_compress, (cmd.take_byte && pos == LAST_POS) |=> cmd.round_en)
	// the digest is never loaded over one still waiting
	`MD5HE_ASSERT(a_no_digest_overrun, cmd.finish |-> (!out_valid || out_ready))
	// padding is always followed by a compression
	`MD5HE_ASSERT(a_pad_then_round, cmd.pad |=> (cmd.round_en && cmd.round_idx == 6'd0))
	// no output beat pending while reset is applied
	`MD5HE_ASSERT_ALWAYS(a_reset_no_output, !arst_n |-> !out_valid)

endmodule
